@@ rtl/gkr_pkg.sv @@
// ---------------------------------------------------------------------------
// gkr_pkg: shared definitions for the gaussian kernel regression block
// Sizes, register codes and the exponential weight table.
// ---------------------------------------------------------------------------
package gkr_pkg;

  localparam int NUM_CENTERS     = 64;
  localparam int NUM_AXES        = 14;
  localparam int EXP_TABLE_DEPTH = 256;

  localparam int CTR_W   = $clog2(NUM_CENTERS);
  localparam int CIU_W   = 7;
  localparam int AXIS_W  = 4;
  localparam int VADDR_W = $clog2(NUM_CENTERS * NUM_AXES);
  localparam int TAB_W   = $clog2(EXP_TABLE_DEPTH);
  localparam int ACC_W   = 40;
  localparam int WTOT_W  = 24;
  localparam int U_W     = 49;
  // u is Q.32; index = u * depth / 16, so the index sits at bit 36 - TAB_W
  localparam int IDX_LSB = 36 - TAB_W;

  // configuration register indexes
  localparam logic [1:0] CFG_EXP_SCALE    = 2'd0;
  localparam logic [1:0] CFG_CENTERS_USED = 2'd1;

  // word select codes for center coordinates
  localparam logic [3:0] WS_CENTER_X = 4'd14;
  localparam logic [3:0] WS_CENTER_Y = 4'd15;

  // series terms of exp(-16 / depth) in Q0.30, each truncated from the last
  localparam longint WT_T0  = longint'(1) <<< 30;
  localparam longint WT_T1  = (WT_T0  * 16) / (longint'(EXP_TABLE_DEPTH) * 1);
  localparam longint WT_T2  = (WT_T1  * 16) / (longint'(EXP_TABLE_DEPTH) * 2);
  localparam longint WT_T3  = (WT_T2  * 16) / (longint'(EXP_TABLE_DEPTH) * 3);
  localparam longint WT_T4  = (WT_T3  * 16) / (longint'(EXP_TABLE_DEPTH) * 4);
  localparam longint WT_T5  = (WT_T4  * 16) / (longint'(EXP_TABLE_DEPTH) * 5);
  localparam longint WT_T6  = (WT_T5  * 16) / (longint'(EXP_TABLE_DEPTH) * 6);
  localparam longint WT_T7  = (WT_T6  * 16) / (longint'(EXP_TABLE_DEPTH) * 7);
  localparam longint WT_T8  = (WT_T7  * 16) / (longint'(EXP_TABLE_DEPTH) * 8);
  localparam longint WT_T9  = (WT_T8  * 16) / (longint'(EXP_TABLE_DEPTH) * 9);
  localparam longint WT_T10 = (WT_T9  * 16) / (longint'(EXP_TABLE_DEPTH) * 10);
  localparam longint WT_T11 = (WT_T10 * 16) / (longint'(EXP_TABLE_DEPTH) * 11);
  localparam longint WT_T12 = (WT_T11 * 16) / (longint'(EXP_TABLE_DEPTH) * 12);
  localparam longint WT_R   = WT_T0 - WT_T1 + WT_T2 - WT_T3 + WT_T4 - WT_T5 + WT_T6
                            - WT_T7 + WT_T8 - WT_T9 + WT_T10 - WT_T11 + WT_T12;

  typedef logic [15:0] wtab_t [EXP_TABLE_DEPTH];

  // exp(-16 i / depth) in Q0.16, built from a truncated series and powers
  function automatic wtab_t build_wtab();
    wtab_t             tab;
    longint unsigned   t;
    longint unsigned   w;
    t = longint'(1) << 30;
    for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
      if (i > 0) t = (t * longint'(WT_R) + (longint'(1) << 29)) >> 30;
      w = (t + (longint'(1) << 13)) >> 14;
      tab[i] = (w > 65535) ? 16'hFFFF : w[15:0];
    end
    return tab;
  endfunction

endpackage

@@ rtl/gaussian_kernel_regression.sv @@
// ---------------------------------------------------------------------------
// gaussian_kernel_regression: kernel-weighted average over a center table
// Loads fill center coordinates and values; a query returns 14 averages.
// ---------------------------------------------------------------------------
// A query walks the centers in use one at a time: it reads the coordinates
// and forms the weight, then streams the 14 values from the value memory
// through the multiply and accumulate pipeline (a center beyond the table
// range skips the value walk). Then each of the 14 results passes through
// the bit-serial divider and the output handshake (the divider is skipped
// when the total weight is zero). New requests are taken only when the
// block is idle.
module gaussian_kernel_regression (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  // request stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // entry_index[5:0], word_select[9:6], word_value[25:10],
  // query_x[41:26], query_y[57:42], zero[63:58]
  input  logic [63:0] s_axis_tdata_i,
  // mode[0]
  input  logic        s_axis_tuser_i,
  // result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // axis_index[3:0], axis_value[19:4], zero[23:20]
  output logic [23:0] m_axis_tdata_o,
  // no_weight[0]
  output logic        m_axis_tuser_o,
  output logic        m_axis_tlast_o
);

  localparam gkr_pkg::wtab_t WTAB = gkr_pkg::build_wtab();
  localparam int CTR_W   = gkr_pkg::CTR_W;
  localparam int VADDR_W = gkr_pkg::VADDR_W;
  localparam int AXIS_W  = gkr_pkg::AXIS_W;
  localparam int ACC_W   = gkr_pkg::ACC_W;
  localparam int WTOT_W  = gkr_pkg::WTOT_W;
  localparam int CIU_W   = gkr_pkg::CIU_W;
  localparam int U_W     = gkr_pkg::U_W;
  localparam int TAB_W   = gkr_pkg::TAB_W;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_CRD   = 11'b00000000010,
    S_DIFF  = 11'b00000000100,
    S_SQ    = 11'b00000001000,
    S_SCL   = 11'b00000010000,
    S_WGT   = 11'b00000100000,
    S_AXES  = 11'b00001000000,
    S_DRAIN = 11'b00010000000,
    S_DIV   = 11'b00100000000,
    S_DWAIT = 11'b01000000000,
    S_OUT   = 11'b10000000000
  } state_e;

  state_e state_q;

  // request fields
  logic              req_mode;
  logic [5:0]        req_entry;
  logic [3:0]        req_ws;
  logic [15:0]       req_value;
  logic [15:0]       req_qx;
  logic [15:0]       req_qy;
  logic              req_acc;

  assign req_mode  = s_axis_tuser_i;
  assign req_entry = s_axis_tdata_i[5:0];
  assign req_ws    = s_axis_tdata_i[9:6];
  assign req_value = s_axis_tdata_i[25:10];
  assign req_qx    = s_axis_tdata_i[41:26];
  assign req_qy    = s_axis_tdata_i[57:42];

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign req_acc         = s_axis_tvalid_i && s_axis_tready_o;

  // configuration registers
  logic [15:0]      exp_scale_q;
  logic [CIU_W-1:0] centers_used_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_scale_q    <= 16'd128;
      centers_used_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        gkr_pkg::CFG_EXP_SCALE:    exp_scale_q    <= cfg_data_i;
        gkr_pkg::CFG_CENTERS_USED: centers_used_q <= cfg_data_i[CIU_W-1:0];
        default: ;
      endcase
    end
  end

  // control registers
  logic [CTR_W-1:0]   ctr_q;
  logic [CIU_W-1:0]   n_q;
  logic [VADDR_W-1:0] base_q;
  logic [AXIS_W-1:0]  ji_q;
  logic [AXIS_W-1:0]  oj_q;
  logic               rd_v_q;
  logic [AXIS_W-1:0]  rd_j_q;
  logic               prod_v_q;
  logic [AXIS_W-1:0]  prod_j_q;
  logic [WTOT_W-1:0]  wtot_q;

  // payload registers
  logic signed [15:0] qx_q, qy_q;
  logic signed [16:0] dx_q, dy_q;
  logic [31:0]        sqx_q, sqy_q;
  logic [U_W-1:0]     u_q;
  logic [15:0]        w_q;
  logic signed [32:0] prod_q;
  logic signed [ACC_W-1:0] acc_q [gkr_pkg::NUM_AXES];
  logic [15:0]        out_val_q;
  logic               out_nw_q;
  logic               neg_q;

  // memories
  logic [31:0]        coord_mem [gkr_pkg::NUM_CENTERS];
  logic [15:0]        val_mem [gkr_pkg::NUM_CENTERS * gkr_pkg::NUM_AXES];
  logic [31:0]        coord_rd_q;
  logic signed [15:0] val_rd_q;
  logic [VADDR_W-1:0] val_waddr;
  logic [VADDR_W-1:0] val_raddr;
  logic               load_acc;

  assign load_acc  = req_acc && !req_mode;
  assign val_waddr = VADDR_W'(req_entry) * VADDR_W'(gkr_pkg::NUM_AXES) + VADDR_W'(req_ws);
  assign val_raddr = base_q + VADDR_W'(ji_q);

  // coordinate memory, x in the low half and y in the high half
  always_ff @(posedge clk_i) begin
    if (load_acc && req_ws == gkr_pkg::WS_CENTER_X) coord_mem[req_entry][15:0]  <= req_value;
    if (load_acc && req_ws == gkr_pkg::WS_CENTER_Y) coord_mem[req_entry][31:16] <= req_value;
    coord_rd_q <= coord_mem[ctr_q];
  end

  // value memory
  always_ff @(posedge clk_i) begin
    if (load_acc && req_ws < AXIS_W'(gkr_pkg::NUM_AXES)) val_mem[val_waddr] <= req_value;
    val_rd_q <= $signed(val_mem[val_raddr]);
  end

  // distance and weight arithmetic
  logic signed [33:0] sqx_full, sqy_full;
  logic [32:0]        dist_sum;
  logic [U_W-1:0]     u_full;
  logic               u_oor;
  logic [TAB_W-1:0]   w_idx;
  logic [WTOT_W:0]    wtot_sum;
  logic signed [32:0] prod_full;
  logic signed [ACC_W:0] acc_sum;
  logic signed [ACC_W-1:0] acc_sat;

  assign sqx_full = dx_q * dx_q;
  assign sqy_full = dy_q * dy_q;
  assign dist_sum = {1'b0, sqx_q} + {1'b0, sqy_q};
  assign u_full   = U_W'(dist_sum) * U_W'(exp_scale_q);
  assign u_oor    = |u_q[U_W-1:gkr_pkg::IDX_LSB+TAB_W];
  assign w_idx    = u_q[gkr_pkg::IDX_LSB+TAB_W-1:gkr_pkg::IDX_LSB];
  assign wtot_sum = {1'b0, wtot_q} + (WTOT_W+1)'(WTAB[w_idx]);

  assign prod_full = $signed({1'b0, w_q}) * val_rd_q;
  assign acc_sum   = {acc_q[prod_j_q][ACC_W-1], acc_q[prod_j_q]}
                   + {{(ACC_W-32){prod_q[32]}}, prod_q};

  // saturate the accumulator sum
  always_comb begin
    if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
      acc_sat = acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      acc_sat = acc_sum[ACC_W-1:0];
    end
  end

  // divider interface
  logic                div_start;
  logic                div_done;
  logic [ACC_W-1:0]    div_quot;
  logic [ACC_W-1:0]    acc_mag;
  logic [ACC_W-1:0]    div_num;
  logic [ACC_W-1:0]    neg_quot;
  logic [15:0]         div_val;

  assign div_start = (state_q == S_DIV) && (wtot_q != '0);
  assign acc_mag   = acc_q[oj_q][ACC_W-1] ? ACC_W'(-acc_q[oj_q]) : ACC_W'(acc_q[oj_q]);
  assign div_num   = acc_mag + ACC_W'(wtot_q >> 1);
  assign neg_quot  = '0 - div_quot;

  // round and saturate the quotient
  always_comb begin
    if (neg_q) begin
      div_val = (div_quot > ACC_W'(32768)) ? 16'h8000 : neg_quot[15:0];
    end else begin
      div_val = (div_quot > ACC_W'(32767)) ? 16'h7FFF : div_quot[15:0];
    end
  end

  gkr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (wtot_q),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  logic last_center;
  assign last_center = ({1'b0, ctr_q} == n_q - CIU_W'(1));

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ctr_q    <= '0;
      n_q      <= '0;
      base_q   <= '0;
      ji_q     <= '0;
      oj_q     <= '0;
      rd_v_q   <= 1'b0;
      rd_j_q   <= '0;
      prod_v_q <= 1'b0;
      prod_j_q <= '0;
      wtot_q   <= '0;
      for (int i = 0; i < gkr_pkg::NUM_AXES; i++) acc_q[i] <= '0;
    end else begin
      rd_v_q   <= (state_q == S_AXES);
      rd_j_q   <= ji_q;
      prod_v_q <= rd_v_q;
      prod_j_q <= rd_j_q;
      if (prod_v_q) acc_q[prod_j_q] <= acc_sat;

      unique case (state_q)
        S_IDLE: begin
          if (req_acc && req_mode) begin
            ctr_q  <= '0;
            base_q <= '0;
            oj_q   <= '0;
            wtot_q <= '0;
            for (int i = 0; i < gkr_pkg::NUM_AXES; i++) acc_q[i] <= '0;
            if (centers_used_q > CIU_W'(gkr_pkg::NUM_CENTERS)) begin
              n_q <= CIU_W'(gkr_pkg::NUM_CENTERS);
            end else begin
              n_q <= centers_used_q;
            end
            state_q <= (centers_used_q == '0) ? S_DIV : S_CRD;
          end
        end
        S_CRD:  state_q <= S_DIFF;
        S_DIFF: state_q <= S_SQ;
        S_SQ:   state_q <= S_SCL;
        S_SCL:  state_q <= S_WGT;
        S_WGT: begin
          ji_q <= '0;
          if (u_oor) begin
            if (last_center) begin
              state_q <= S_DIV;
            end else begin
              ctr_q   <= ctr_q + CTR_W'(1);
              base_q  <= base_q + VADDR_W'(gkr_pkg::NUM_AXES);
              state_q <= S_CRD;
            end
          end else begin
            wtot_q  <= wtot_sum[WTOT_W] ? '1 : wtot_sum[WTOT_W-1:0];
            state_q <= S_AXES;
          end
        end
        S_AXES: begin
          ji_q <= ji_q + AXIS_W'(1);
          if (ji_q == AXIS_W'(gkr_pkg::NUM_AXES - 1)) state_q <= S_DRAIN;
        end
        S_DRAIN: begin
          if (!rd_v_q && !prod_v_q) begin
            if (last_center) begin
              state_q <= S_DIV;
            end else begin
              ctr_q   <= ctr_q + CTR_W'(1);
              base_q  <= base_q + VADDR_W'(gkr_pkg::NUM_AXES);
              state_q <= S_CRD;
            end
          end
        end
        S_DIV:   state_q <= (wtot_q == '0) ? S_OUT : S_DWAIT;
        S_DWAIT: if (div_done) state_q <= S_OUT;
        S_OUT: begin
          if (m_axis_tready_i) begin
            if (oj_q == AXIS_W'(gkr_pkg::NUM_AXES - 1)) begin
              state_q <= S_IDLE;
            end else begin
              oj_q    <= oj_q + AXIS_W'(1);
              state_q <= S_DIV;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (req_acc && req_mode) begin
      qx_q <= $signed(req_qx);
      qy_q <= $signed(req_qy);
    end
    dx_q   <= {qx_q[15], qx_q} - {coord_rd_q[15], coord_rd_q[15:0]};
    dy_q   <= {qy_q[15], qy_q} - {coord_rd_q[31], coord_rd_q[31:16]};
    sqx_q  <= sqx_full[31:0];
    sqy_q  <= sqy_full[31:0];
    u_q    <= u_full;
    if (state_q == S_WGT) w_q <= WTAB[w_idx];
    prod_q <= prod_full;
    if (state_q == S_DIV) begin
      neg_q     <= acc_q[oj_q][ACC_W-1];
      out_val_q <= '0;
      out_nw_q  <= (wtot_q == '0);
    end
    if (state_q == S_DWAIT && div_done) out_val_q <= div_val;
  end

  // result port
  assign m_axis_tvalid_o = (state_q == S_OUT);
  assign m_axis_tdata_o  = {4'b0, out_val_q, oj_q};
  assign m_axis_tuser_o  = out_nw_q;
  assign m_axis_tlast_o  = (oj_q == AXIS_W'(gkr_pkg::NUM_AXES - 1));

  // checks
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !m_axis_tvalid_o)
    else $error("request taken while a result is pending");

  a_mac_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prod_v_q |-> (state_q == S_AXES || state_q == S_DRAIN))
    else $error("accumulate outside the value walk");

  a_zero_on_nw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> (m_axis_tdata_o[19:4] == 16'd0))
    else $error("nonzero value with zero total weight");

endmodule

@@ rtl/gkr_div.sv @@
// ---------------------------------------------------------------------------
// gkr_div: sequential unsigned divider
// Restoring division, one quotient bit per cycle, 40-bit by 24-bit.
// ---------------------------------------------------------------------------
module gkr_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [gkr_pkg::ACC_W-1:0]    num_i,
  input  logic [gkr_pkg::WTOT_W-1:0]   den_i,
  output logic                         done_o,
  output logic [gkr_pkg::ACC_W-1:0]    quot_o
);

  localparam int CNT_W = $clog2(gkr_pkg::ACC_W + 1);

  logic                         busy_q;
  logic [CNT_W-1:0]             cnt_q;
  logic [gkr_pkg::WTOT_W-1:0]   rem_q;
  logic [gkr_pkg::WTOT_W-1:0]   den_q;
  logic [gkr_pkg::ACC_W-1:0]    num_q;
  logic [gkr_pkg::ACC_W-1:0]    quot_q;
  logic                         done_q;
  logic [gkr_pkg::WTOT_W:0]     rem_sh;
  logic                         ge;
  logic [gkr_pkg::WTOT_W:0]     rem_sub;

  // one restoring step
  assign rem_sh  = {rem_q, num_q[gkr_pkg::ACC_W-1]};
  assign ge      = (rem_sh >= {1'b0, den_q});
  assign rem_sub = rem_sh - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(gkr_pkg::ACC_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= '0;
      den_q  <= den_i;
      num_q  <= num_i;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= ge ? rem_sub[gkr_pkg::WTOT_W-1:0] : rem_sh[gkr_pkg::WTOT_W-1:0];
      num_q  <= {num_q[gkr_pkg::ACC_W-2:0], 1'b0};
      quot_q <= {quot_q[gkr_pkg::ACC_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule
